// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_NEGIDX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RD,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/dq_divider.sv =====
// ----------------------------------------------------------------------------
// dq_divider
// Restoring remainder unit: one dividend bit per cycle, remainder of a
// non-negative word by the entry count.
// ----------------------------------------------------------------------------
module dq_divider #(
  parameter int unsigned AddrW = 8,
  parameter int unsigned CntW  = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dq_pkg::DATA_W-1:0]  dividend_i,
  input  logic [CntW-1:0]            divisor_i,
  output logic                       done_o,
  output logic [AddrW-1:0]           rem_o
);
  import dq_pkg::*;

  localparam int unsigned IterW = $clog2(DATA_W);
  localparam int unsigned RemW  = AddrW + 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [CntW-1:0]   dvs_q, dvs_d;
  logic [AddrW-1:0]  rem_q, rem_d;
  logic [RemW-1:0]   shifted;
  logic [RemW-1:0]   diff;

  assign shifted = {rem_q, dvd_q[DATA_W-1]};
  assign diff    = shifted - RemW'(dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the address width
      if (shifted >= RemW'(dvs_q)) begin
        rem_d = diff[AddrW-1:0];
      end else begin
        rem_d = shifted[AddrW-1:0];
      end
      dvd_d  = {dvd_q[DATA_W-2:0], 1'b0};
      iter_d = iter_q + 1'b1;
      if (iter_q == IterW'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a ring buffer memory.
// ----------------------------------------------------------------------------
// One request at a time. Each request carries an opcode (push front, push
// back, pop front, pop back, indexed read) and gives exactly one result with
// status, a value and the entry count after the request. After acceptance,
// pushes, pops and error cases take these steps: one to update head/count
// and write the memory, one to read the front entry from the synchronous
// store, one to load the output register once it is free. A good indexed
// read first waits for the remainder unit, which reduces the index modulo
// the count one bit per cycle. The store is not cleared after reset; only
// entries inside the count are ever read. The output register lets the
// result wait for the consumer; a further request is held off until the
// pending result has been loaded into it.
module double_ended_queue #(
  parameter int unsigned CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    opcode_i,
  input  logic signed [31:0]            entry_value_i,
  input  logic signed [31:0]            read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [31:0]            result_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);
  import dq_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  // ring index helpers
  function automatic logic [AddrW-1:0] slot_after(logic [AddrW-1:0] pos,
                                                  logic [AddrW-1:0] off);
    logic [AddrW:0] s;
    s = {1'b0, pos} + {1'b0, off};
    if (s >= (AddrW+1)'(CAPACITY)) begin
      s = s - (AddrW+1)'(CAPACITY);
    end
    return s[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] slot_before(logic [AddrW-1:0] pos);
    logic [AddrW-1:0] r;
    r = (pos == '0) ? AddrW'(CAPACITY - 1) : pos - 1'b1;
    return r;
  endfunction

  // entry store
  logic [DATA_W-1:0] mem [CAPACITY];
  logic              mem_we;
  logic [AddrW-1:0]  mem_wa;
  logic [DATA_W-1:0] rd_data_q;

  // control state
  state_e            state_q, state_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;

  // request and pending-result registers
  logic [2:0]        op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] idx_q;
  status_e           stat_q, stat_d;
  logic [AddrW-1:0]  rd_addr_q, rd_addr_d;
  logic              use_val_q, use_val_d;
  logic              zero_q, zero_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [1:0]        out_stat_q;
  logic [DATA_W-1:0] out_val_q;
  logic [CntW-1:0]   out_cnt_q;

  // remainder unit
  logic              div_start;
  logic              div_done;
  logic [AddrW-1:0]  div_rem;

  logic              full, empty, in_acc;

  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign in_acc = in_valid_i && in_ready_o;

  assign in_ready_o = (state_q == ST_IDLE);

  dq_divider #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (idx_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    stat_d    = stat_q;
    rd_addr_d = rd_addr_q;
    use_val_d = use_val_q;
    zero_d    = zero_q;
    mem_we    = 1'b0;
    mem_wa    = head_q;
    div_start = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // default: report the front entry, or zero when empty
        stat_d    = STAT_OK;
        rd_addr_d = head_q;
        use_val_d = 1'b0;
        zero_d    = empty;
        state_d   = ST_RD;
        case (op_q)
          OP_PUSH_FRONT: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              head_d    = slot_before(head_q);
              mem_we    = 1'b1;
              mem_wa    = slot_before(head_q);
              count_d   = count_q + 1'b1;
              use_val_d = 1'b1;
              zero_d    = 1'b0;
            end
          end
          OP_PUSH_BACK: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              // count below capacity here, so its low bits are the offset
              mem_we    = 1'b1;
              mem_wa    = slot_after(head_q, count_q[AddrW-1:0]);
              count_d   = count_q + 1'b1;
              use_val_d = empty;
              zero_d    = 1'b0;
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              stat_d = STAT_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
              if (count_q == CntW'(1)) begin
                head_d = '0;
                zero_d = 1'b1;
              end else begin
                head_d    = slot_after(head_q, AddrW'(1));
                rd_addr_d = slot_after(head_q, AddrW'(1));
              end
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              stat_d = STAT_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
              if (count_q == CntW'(1)) begin
                head_d = '0;
                zero_d = 1'b1;
              end
            end
          end
          OP_READ: begin
            if (empty) begin
              stat_d = STAT_EMPTY;
            end else if (idx_q[DATA_W-1]) begin
              stat_d = STAT_NEGIDX;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          default: ;
        endcase
      end

      ST_DIV: begin
        if (div_done) begin
          rd_addr_d = slot_after(head_q, div_rem);
          state_d   = ST_RD;
        end
      end

      ST_RD: begin
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      val_q <= entry_value_i;
      idx_q <= read_index_i;
    end
    stat_q    <= stat_d;
    rd_addr_q <= rd_addr_d;
    use_val_q <= use_val_d;
    zero_q    <= zero_d;
    if (out_load) begin
      out_stat_q <= stat_q;
      out_cnt_q  <= count_q;
      if (zero_q) begin
        out_val_q <= '0;
      end else if (use_val_q) begin
        out_val_q <= val_q;
      end else begin
        out_val_q <= rd_data_q;
      end
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= val_q;
    end
    if (state_q == ST_RD) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign result_value_o = out_val_q;
  assign entry_count_o  = out_cnt_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("head not parked at zero when empty");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("remainder finished outside divide state");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_EXEC) && !full)
    else $error("store written when full or out of sequence");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended queue: directed corner requests,
// fill and overflow, random traffic and back-to-back bursts, checked against
// a shadow ring buffer kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  localparam int unsigned CAP       = CAPACITY_DEF;
  localparam int unsigned COUNT_W   = $clog2(CAP + 1);
  localparam int unsigned SLOT_W    = $clog2(CAP);
  localparam int          IDLE_LIMIT = 4000;   // cycles with no handshake at all
  localparam int          LONG_HOLD  = 400;    // long consumer stall
  localparam int          TAIL_WAIT  = 64;     // > one indexed read

  // Opcodes the block has no meaning for; they must leave the state alone.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    status_e              status;
    logic [31:0]          value;
    logic [COUNT_W-1:0]   count;
  } deque_result_t;

  // DUT connections; the bench-driven ones are known from time zero.
  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready_o;
  logic [2:0]                opcode         = '0;
  logic signed [31:0]        entry_value    = '0;
  logic signed [31:0]        read_index     = '0;
  logic                      out_valid_o;
  logic                      out_ready      = 1'b0;
  logic [1:0]                status_o;
  logic signed [31:0]        result_value_o;
  logic [COUNT_W-1:0]        entry_count_o;

  // Shadow copy of the queue state.
  logic [31:0]               shadow_store [CAP];
  int unsigned               shadow_head  = 0;
  int unsigned               shadow_count = 0;

  deque_result_t             pending_results[$];
  int                        mismatch_count = 0;
  int                        idle_cycles    = 0;
  int                        hold_req       = 0;   // consumer hold-off request
  bit                        no_stall       = 1'b0; // both sides at full rate

  double_ended_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode),
    .entry_value_i  (entry_value),
    .read_index_i   (read_index),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow queue: applies one accepted request and returns its result.
  // --------------------------------------------------------------------------
  function automatic deque_result_t predict_deque(logic [2:0] op, logic [31:0] val,
                                                  logic [31:0] idx);
    deque_result_t r;
    bit            have_read;
    int unsigned   offset;
    r.status  = STAT_OK;
    r.value   = '0;
    have_read = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= CAP) begin
          r.status = STAT_FULL;        // dropped, nothing moves
        end else begin
          shadow_head = (shadow_head + CAP - 1) % CAP;
          shadow_store[SLOT_W'(shadow_head)] = val;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          shadow_store[SLOT_W'((shadow_head + shadow_count) % CAP)] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % CAP;
          shadow_count--;
          if (shadow_count == 0) shadow_head = 0;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          shadow_count--;
          if (shadow_count == 0) shadow_head = 0;
        end
      end
      OP_READ: begin
        // empty wins over a negative index; no divide on an empty queue
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (idx[31]) begin
          r.status = STAT_NEGIDX;
        end else begin
          offset    = idx % shadow_count;
          r.value   = shadow_store[SLOT_W'((shadow_head + offset) % CAP)];
          have_read = 1'b1;
        end
      end
      default: ;                         // spare opcodes change nothing
    endcase
    if (!have_read)
      r.value = (shadow_count == 0) ? 32'd0 : shadow_store[SLOT_W'(shadow_head)];
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Producer: offers one request after a random gap and waits for acceptance.
  // Valid is only lowered when a gap follows, so it never drops and rises in
  // the same step.
  // --------------------------------------------------------------------------
  task automatic send_request(logic [2:0] op, logic [31:0] val, logic [31:0] idx);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_value <= val;
    read_index  <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_deque(op, val, idx));
  endtask

  // Pause the producer until every outstanding result has been taken.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random value, now and then a signed extreme, minus one or zero.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'hffff_ffff;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Read index: mostly near the count so wrapping is common, some full-range
  // and some negative.
  function automatic logic [31:0] pick_index();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      6, 7:    v = $urandom;
      8:       v = {1'b1, 31'($urandom)};
      9: begin
        case ($urandom_range(0, 2))
          0:       v = shadow_count;
          1:       v = (shadow_count == 0) ? 32'd0 : shadow_count - 1;
          default: v = 32'h7fff_ffff;
        endcase
      end
      default: v = $urandom_range(0, 2 * shadow_count + 1);
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_spare();
    logic [2:0] op;
    case ($urandom_range(0, 2))
      0:       op = OP_SPARE_5;
      1:       op = OP_SPARE_6;
      default: op = OP_SPARE_7;
    endcase
    return op;
  endfunction

  // One random request; push_pct sets how much of the push/pop share pushes.
  task automatic random_request(int push_pct);
    int          r;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      op = pick_spare();
    end else if (r < 25) begin
      op = OP_READ;
    end else if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    end
    send_request(op, pick_value(), pick_index());
  endtask

  // --------------------------------------------------------------------------
  // Consumer: random stalls, plus a long hold-off when one is requested.
  // --------------------------------------------------------------------------
  initial begin : consumer
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      gap = no_stall ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: status %0d value %0d count %0d",
                   $realtime, status_o, result_value_o, entry_count_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || result_value_o !== want.value ||
            entry_count_o !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: status %0d/%0d value %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, want.status, status_o, $signed(want.value),
                     result_value_o, want.count, entry_count_o);
        end
      end
    end
  end

  // Watchdog: ends the run if no handshake happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Everything on an empty queue: pops, reads (empty beats negative index),
  // spare opcodes.
  task automatic test_empty_queue();
    send_request(OP_POP_FRONT, 32'h1234_5678, 32'd0);
    send_request(OP_POP_BACK,  32'd0,         32'd0);
    send_request(OP_READ,      32'd0,         32'd0);
    send_request(OP_READ,      32'd0,         32'hffff_ffff);
    send_request(OP_SPARE_5,   32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_SPARE_6,   32'd0,         32'd0);
    send_request(OP_SPARE_7,   32'h8000_0000, 32'h8000_0000);
    wait_drained();
  endtask

  // Value extremes, index wrap, negative index, draining to empty at both ends.
  task automatic test_extremes();
    send_request(OP_PUSH_FRONT, 32'h7fff_ffff, 32'd0);
    send_request(OP_PUSH_BACK,  32'h8000_0000, 32'd0);
    send_request(OP_PUSH_BACK,  32'h0000_0000, 32'd0);
    send_request(OP_PUSH_FRONT, 32'hffff_ffff, 32'd0);
    send_request(OP_READ,       32'd0,         32'd0);
    send_request(OP_READ,       32'd0,         32'd3);
    send_request(OP_READ,       32'd0,         32'h7fff_ffff);  // wraps mod count
    send_request(OP_READ,       32'd0,         32'h8000_0000);
    send_request(OP_READ,       32'd0,         32'hffff_ffff);
    send_request(OP_SPARE_5,    32'h5555_5555, 32'd1);
    send_request(OP_POP_BACK,   32'd0,         32'd0);
    send_request(OP_POP_FRONT,  32'd0,         32'd0);
    send_request(OP_POP_FRONT,  32'd0,         32'd0);
    send_request(OP_POP_BACK,   32'd0,         32'd0);          // back to empty
    send_request(OP_PUSH_BACK,  32'h0000_0001, 32'd0);
    send_request(OP_POP_FRONT,  32'd0,         32'd0);
    wait_drained();
  endtask

  // Fill to capacity under a long consumer hold-off, push into a full queue,
  // read across the whole ring, then drain it again.
  task automatic test_fill_and_overflow();
    hold_req = LONG_HOLD;
    repeat (CAP)
      send_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(), 32'd0);
    repeat (3) send_request(OP_PUSH_FRONT, pick_value(), 32'd0);
    repeat (3) send_request(OP_PUSH_BACK,  pick_value(), 32'd0);
    repeat (20) send_request(OP_READ, pick_value(), pick_index());
    send_request(OP_READ, 32'd0, CAP - 1);
    send_request(OP_SPARE_6, pick_value(), pick_index());
    wait_drained();
    while (shadow_count > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_request(OP_READ, pick_value(), pick_index());
      else
        send_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value(),
                     pick_index());
    end
    send_request(OP_POP_BACK, pick_value(), 32'd0);
    wait_drained();
  endtask

  // Mixed traffic in phases that grow, shrink or hold the fill level.
  task automatic test_random_traffic();
    int push_pct;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (100) random_request(push_pct);
    end
    wait_drained();
  endtask

  // No idling on either side.
  task automatic test_back_to_back();
    no_stall = 1'b1;
    repeat (150) random_request(70);
    repeat (150) random_request(35);
    wait_drained();
    no_stall = 1'b0;
  endtask

  initial begin : main
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extremes();
    test_fill_and_overflow();
    test_random_traffic();
    test_back_to_back();

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d results never arrived", pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
